/* hdl/spd_pkg.sv */
package spd_pkg;

  localparam int NUM_CHANNELS  = 16;
  localparam int FIRST_VIRTUAL = 1;

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int FIRST_PTR = (FIRST_VIRTUAL >= NUM_CHANNELS) ? NUM_CHANNELS - 1 : FIRST_VIRTUAL;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] FUNC_EDGE = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PULSE_MIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_GAP_MAX      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_SERVO_GAP_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_VALUE_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT_TICKS    = 3'd4;

  localparam logic [15:0] RST_SYNC_PULSE_MIN       = 16'd4000;
  localparam logic [15:0] RST_CHANNEL_GAP_MAX      = 16'd550;
  localparam logic [15:0] RST_SINGLE_SERVO_GAP_MIN = 16'd16000;
  localparam logic [15:0] RST_CHANNEL_VALUE_OFFSET = 16'd500;
  localparam logic [15:0] RST_STALE_LIMIT_TICKS    = 16'd200;

  typedef struct packed {
    logic            duty_we;
    logic            pause_we;
    logic [CH_W-1:0] addr;
    logic [15:0]     duty;
    logic [31:0]     upd;
    logic [15:0]     pause;
  } wr_req_t;

endpackage

/* hdl/spd_chan_mem.sv */
module spd_chan_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  spd_pkg::wr_req_t            wr,
  input  logic                        rd_en,
  input  logic [spd_pkg::CH_W-1:0]    rd_addr,
  output logic [15:0]                 rd_duty,
  output logic [15:0]                 rd_pause,
  output logic [31:0]                 rd_upd
);

  logic [15:0] duty_mem_r  [spd_pkg::NUM_CHANNELS];
  logic [15:0] pause_mem_r [spd_pkg::NUM_CHANNELS];
  logic [31:0] upd_mem_r   [spd_pkg::NUM_CHANNELS];

  logic [spd_pkg::NUM_CHANNELS-1:0] dvld_r;
  logic [spd_pkg::NUM_CHANNELS-1:0] pvld_r;

  logic [15:0] duty_q_r;
  logic [15:0] pause_q_r;
  logic [31:0] upd_q_r;
  logic        dvld_q_r;
  logic        pvld_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r <= '0;
      pvld_r <= '0;
    end else begin
      if (wr.duty_we) begin
        dvld_r[wr.addr] <= 1'b1;
      end
      if (wr.pause_we) begin
        pvld_r[wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.duty_we) begin
      duty_mem_r[wr.addr] <= wr.duty;
      upd_mem_r[wr.addr]  <= wr.upd;
    end
    if (wr.pause_we) begin
      pause_mem_r[wr.addr] <= wr.pause;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      duty_q_r  <= duty_mem_r[rd_addr];
      pause_q_r <= pause_mem_r[rd_addr];
      upd_q_r   <= upd_mem_r[rd_addr];
      dvld_q_r  <= dvld_r[rd_addr];
      pvld_q_r  <= pvld_r[rd_addr];
    end
  end

  // Entries never written read as zero.
  assign rd_duty  = dvld_q_r ? duty_q_r  : '0;
  assign rd_upd   = dvld_q_r ? upd_q_r   : '0;
  assign rd_pause = pvld_q_r ? pause_q_r : '0;

endmodule

/* hdl/sum_ppm_servo_pulse_decoder.sv */
// Sum-PPM and servo pulse decoder. One transaction is accepted every clock cycle unless a
// finished read waits in the memory stage behind a stalled result, and then the input
// stalls until the result moves. Edge captures and ticks update the state in the cycle
// they are accepted and give no result, and a channel read delivers its duty and pause
// through the synchronous read of the channel memory and then the staleness check, which
// registers the result.
// Channel 0 lives in registers because every edge writes it; the virtual channels live
// in the memory, which takes one write per cycle.
module sum_ppm_servo_pulse_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_func,
  input  logic [15:0]                     in_capture_time,
  input  logic [7:0]                      in_channel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     out_duty_value,
  output logic [15:0]                     out_pause_value,
  input  logic                            cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_wdata
);

  logic [15:0] sync_min_r;
  logic [15:0] gap_max_r;
  logic [15:0] servo_min_r;
  logic [15:0] offset_r;
  logic [15:0] stale_r;

  logic [15:0]             rise_r, rise_nxt;
  logic [15:0]             fall_r, fall_nxt;
  logic                    exp_fall_r, exp_fall_nxt;
  logic [spd_pkg::CH_W-1:0] ptr_r, ptr_nxt;
  logic                    active_r, active_nxt;
  logic [31:0]             tick_r, tick_nxt;
  logic [15:0]             duty0_r, duty0_nxt;
  logic [15:0]             pause0_r, pause0_nxt;
  logic [31:0]             upd0_r, upd0_nxt;

  logic                    s1_v_r, s1_v_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    s1_range_r;
  logic                    s1_zero_r;
  logic [31:0]             s1_tick_r;
  logic [15:0]             s1_d0_r;
  logic [15:0]             s1_p0_r;
  logic [31:0]             s1_u0_r;
  logic [15:0]             out_duty_r;
  logic [15:0]             out_pause_r;

  logic        accept;
  logic        is_edge;
  logic        is_tick;
  logic        is_read;
  logic        out_free;
  logic        s1_adv;
  logic [15:0] diff;
  logic [15:0] last_stamp;
  spd_pkg::wr_req_t wr;

  logic [15:0] mem_duty;
  logic [15:0] mem_pause;
  logic [31:0] mem_upd;
  logic [15:0] sel_duty;
  logic [15:0] sel_pause;
  logic [31:0] sel_upd;
  logic [31:0] age;
  logic        fresh;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    is_edge = 1'b0;
    is_tick = 1'b0;
    is_read = 1'b0;
    unique case (in_func)
      spd_pkg::FUNC_EDGE: is_edge = accept;
      spd_pkg::FUNC_TICK: is_tick = accept;
      spd_pkg::FUNC_READ: is_read = accept;
      default: ;
    endcase
  end

  assign last_stamp = exp_fall_r ? rise_r : fall_r;
  assign diff       = in_capture_time - last_stamp;

  always_comb begin
    rise_nxt     = rise_r;
    fall_nxt     = fall_r;
    exp_fall_nxt = exp_fall_r;
    ptr_nxt      = ptr_r;
    active_nxt   = active_r;
    tick_nxt     = tick_r;
    duty0_nxt    = duty0_r;
    pause0_nxt   = pause0_r;
    upd0_nxt     = upd0_r;
    wr.duty_we   = 1'b0;
    wr.pause_we  = 1'b0;
    wr.addr      = ptr_r;
    wr.duty      = diff + offset_r;
    wr.upd       = tick_r;
    wr.pause     = diff;
    if (is_tick) begin
      tick_nxt = tick_r + 32'd1;
    end
    if (is_edge) begin
      exp_fall_nxt = !exp_fall_r;
      if (exp_fall_r) begin
        fall_nxt = in_capture_time;
        if (diff > sync_min_r) begin
          // A long high time is the frame sync pause.
          pause0_nxt = diff;
          ptr_nxt    = spd_pkg::CH_W'(spd_pkg::FIRST_PTR);
          active_nxt = 1'b1;
        end else begin
          wr.duty_we = active_r;
          duty0_nxt  = diff;
          upd0_nxt   = tick_r;
        end
      end else begin
        rise_nxt   = in_capture_time;
        pause0_nxt = diff;
        if (diff < gap_max_r && active_r) begin
          wr.pause_we = 1'b1;
          if (ptr_r != spd_pkg::CH_W'(spd_pkg::NUM_CHANNELS - 1)) begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end else if (diff > servo_min_r) begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  assign s1_v_nxt      = is_read || (s1_v_r && !out_free);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_min_r  <= spd_pkg::RST_SYNC_PULSE_MIN;
      gap_max_r   <= spd_pkg::RST_CHANNEL_GAP_MAX;
      servo_min_r <= spd_pkg::RST_SINGLE_SERVO_GAP_MIN;
      offset_r    <= spd_pkg::RST_CHANNEL_VALUE_OFFSET;
      stale_r     <= spd_pkg::RST_STALE_LIMIT_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spd_pkg::CFG_SYNC_PULSE_MIN:       sync_min_r  <= cfg_wdata;
        spd_pkg::CFG_CHANNEL_GAP_MAX:      gap_max_r   <= cfg_wdata;
        spd_pkg::CFG_SINGLE_SERVO_GAP_MIN: servo_min_r <= cfg_wdata;
        spd_pkg::CFG_CHANNEL_VALUE_OFFSET: offset_r    <= cfg_wdata;
        spd_pkg::CFG_STALE_LIMIT_TICKS:    stale_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r      <= '0;
      fall_r      <= '0;
      exp_fall_r  <= 1'b0;
      ptr_r       <= '0;
      active_r    <= 1'b0;
      tick_r      <= '0;
      duty0_r     <= '0;
      pause0_r    <= '0;
      upd0_r      <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rise_r      <= rise_nxt;
      fall_r      <= fall_nxt;
      exp_fall_r  <= exp_fall_nxt;
      ptr_r       <= ptr_nxt;
      active_r    <= active_nxt;
      tick_r      <= tick_nxt;
      duty0_r     <= duty0_nxt;
      pause0_r    <= pause0_nxt;
      upd0_r      <= upd0_nxt;
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      s1_range_r <= in_channel < 8'(spd_pkg::NUM_CHANNELS);
      s1_zero_r  <= in_channel == 8'd0;
      s1_tick_r  <= tick_r;
      s1_d0_r    <= duty0_r;
      s1_p0_r    <= pause0_r;
      s1_u0_r    <= upd0_r;
    end
  end

  spd_chan_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd_en    (is_read),
    .rd_addr  (in_channel[spd_pkg::CH_W-1:0]),
    .rd_duty  (mem_duty),
    .rd_pause (mem_pause),
    .rd_upd   (mem_upd)
  );

  assign sel_duty  = s1_zero_r ? s1_d0_r : mem_duty;
  assign sel_pause = s1_zero_r ? s1_p0_r : mem_pause;
  assign sel_upd   = s1_zero_r ? s1_u0_r : mem_upd;
  assign age       = s1_tick_r - sel_upd;
  assign fresh     = age < {16'd0, stale_r};

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_duty_r  <= (s1_range_r && fresh) ? sel_duty : '0;
      out_pause_r <= s1_range_r ? sel_pause : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_duty_value  = out_duty_r;
  assign out_pause_value = out_pause_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= spd_pkg::CH_W'(spd_pkg::NUM_CHANNELS - 1))
    else $error("Virtual channel pointer beyond the last channel.");

  assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> ptr_r != '0)
    else $error("Sum-PPM mode active with the pointer on channel 0.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (wr.duty_we || wr.pause_we) |-> wr.addr != '0)
    else $error("Virtual channel write aimed at channel 0.");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && out_valid_r && out_stall))
    else $error("Input stalled while the read pipeline can move.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_free) |=> s1_v_r)
    else $error("Read transaction dropped from the memory stage.");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 250;

  typedef struct {
    logic [15:0] duty;
    logic [15:0] pause;
  } readback_t;

  // Tracks the decoder's channel table and holds the read-backs still owed by the block.
  class ppm_channel_scoreboard;
    logic [15:0] sync_min, gap_max, servo_gap_min, value_offset, stale_limit;
    logic [15:0] duty_tab[spd_pkg::NUM_CHANNELS];
    logic [15:0] pause_tab[spd_pkg::NUM_CHANNELS];
    logic [31:0] stamp_tab[spd_pkg::NUM_CHANNELS];
    logic [15:0] rise_t, fall_t;
    bit          falling_next, sum_ppm;
    int unsigned ptr;
    logic [31:0] ticks;
    readback_t   pending_reads[$];
    int          errors;

    function new();
      sync_min = spd_pkg::RST_SYNC_PULSE_MIN;
      gap_max = spd_pkg::RST_CHANNEL_GAP_MAX;
      servo_gap_min = spd_pkg::RST_SINGLE_SERVO_GAP_MIN;
      value_offset = spd_pkg::RST_CHANNEL_VALUE_OFFSET;
      stale_limit = spd_pkg::RST_STALE_LIMIT_TICKS;
      for (int i = 0; i < spd_pkg::NUM_CHANNELS; i++) begin
        duty_tab[i] = '0;
        pause_tab[i] = '0;
        stamp_tab[i] = '0;
      end
      rise_t = '0;
      fall_t = '0;
      falling_next = 0;
      sum_ppm = 0;
      ptr = 0;
      ticks = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [spd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] v);
      case (idx)
        spd_pkg::CFG_SYNC_PULSE_MIN:       sync_min = v;
        spd_pkg::CFG_CHANNEL_GAP_MAX:      gap_max = v;
        spd_pkg::CFG_SINGLE_SERVO_GAP_MIN: servo_gap_min = v;
        spd_pkg::CFG_CHANNEL_VALUE_OFFSET: value_offset = v;
        spd_pkg::CFG_STALE_LIMIT_TICKS:    stale_limit = v;
        default: ;
      endcase
    endfunction

    function int unsigned clamp(int unsigned p);
      return (p >= spd_pkg::NUM_CHANNELS) ? spd_pkg::NUM_CHANNELS - 1 : p;
    endfunction

    function void apply_edge(logic [15:0] t);
      logic [15:0] span;
      int unsigned p;
      if (falling_next) begin
        fall_t = t;
        span = fall_t - rise_t;
        falling_next = 0;
        if (span > sync_min) begin
          pause_tab[0] = span;
          ptr = clamp(spd_pkg::FIRST_VIRTUAL);
          sum_ppm = 1;
        end else begin
          if (sum_ppm) begin
            p = clamp(ptr);
            duty_tab[p] = span + value_offset;
            stamp_tab[p] = ticks;
          end
          duty_tab[0] = span;
          stamp_tab[0] = ticks;
        end
      end else begin
        rise_t = t;
        falling_next = 1;
        span = rise_t - fall_t;
        if (span < gap_max && sum_ppm) begin
          p = clamp(ptr);
          pause_tab[p] = span;
          ptr = clamp(p + 1);
        end else if (span > servo_gap_min) begin
          sum_ppm = 0;
        end
        pause_tab[0] = span;
      end
    endfunction

    function void note_transaction(logic [1:0] func, logic [15:0] t, logic [7:0] ch);
      readback_t rb;
      logic [31:0] age;
      case (func)
        spd_pkg::FUNC_EDGE: apply_edge(t);
        spd_pkg::FUNC_TICK: ticks = ticks + 1;
        spd_pkg::FUNC_READ: begin
          rb.duty = '0;
          rb.pause = '0;
          if (ch < spd_pkg::NUM_CHANNELS) begin
            age = ticks - stamp_tab[ch];
            rb.duty = (age < {16'd0, stale_limit}) ? duty_tab[ch] : 16'd0;
            rb.pause = pause_tab[ch];
          end
          pending_reads.push_back(rb);
        end
        default: ;
      endcase
    endfunction

    function void check_readback(logic [15:0] duty, logic [15:0] pause);
      readback_t rb;
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected read-back: expected none, got duty %0d pause %0d",
                 $time, duty, pause);
        errors++;
        return;
      end
      rb = pending_reads.pop_front();
      if (duty !== rb.duty) begin
        $display("%0t: duty mismatch: expected %0d, got %0d", $time, rb.duty, duty);
        errors++;
      end
      if (pause !== rb.pause) begin
        $display("%0t: pause mismatch: expected %0d, got %0d", $time, rb.pause, pause);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    in_func = spd_pkg::FUNC_EDGE;
  logic [15:0]                   in_capture_time = '0;
  logic [7:0]                    in_channel = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [15:0]                   out_duty_value;
  logic [15:0]                   out_pause_value;
  logic                          cfg_we = 1'b0;
  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]                   cfg_wdata = '0;

  ppm_channel_scoreboard sb = new();
  bit          idle_on = 1'b1;
  bit          wire_high = 1'b0;
  logic [15:0] edge_stamp = '0;
  int          n_items = 0;
  int          quiet = 0;

  sum_ppm_servo_pulse_decoder uut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_transaction(in_func, in_capture_time, in_channel);
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_readback(out_duty_value, out_pause_value);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(logic [1:0] func, logic [15:0] t, logic [7:0] ch);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_capture_time <= t;
    in_channel <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (func == spd_pkg::FUNC_EDGE) begin
      wire_high = !wire_high;
      edge_stamp = t;
    end
    if (func != FUNC_UNUSED) n_items++;
  endtask

  task automatic send_edge(int unsigned delta);
    send_item(spd_pkg::FUNC_EDGE, edge_stamp + delta[15:0], 8'($urandom));
  endtask

  task automatic read_channel();
    logic [7:0] ch;
    ch = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(spd_pkg::NUM_CHANNELS, 255))
                                     : 8'($urandom_range(0, spd_pkg::NUM_CHANNELS - 1));
    send_item(spd_pkg::FUNC_READ, 16'($urandom), ch);
  endtask

  task automatic maybe_interleave();
    case ($urandom_range(0, 5))
      0: repeat ($urandom_range(1, 4)) begin
        send_item(spd_pkg::FUNC_TICK, 16'($urandom), 8'($urandom));
      end
      1: read_channel();
      default: ;
    endcase
  endtask

  task automatic send_frame();
    int n_ch;
    int lo;
    if (wire_high) send_edge($urandom_range(100, 2000));
    send_edge($urandom_range(600, 3000));
    lo = sb.sync_min + 1;
    send_edge(lo > 65535 ? $urandom : $urandom_range(lo, (lo + 2000 > 65535) ? 65535 : lo + 2000));
    n_ch = $urandom_range(1, spd_pkg::NUM_CHANNELS + 3);
    for (int i = 0; i < n_ch; i++) begin
      maybe_interleave();
      send_edge(sb.gap_max > 0 ? $urandom_range(0, sb.gap_max - 1) : $urandom_range(0, 300));
      maybe_interleave();
      send_edge($urandom_range(700, 2300));
    end
    if ($urandom_range(0, 1) == 0) begin
      lo = sb.servo_gap_min + 1;
      send_edge(lo > 65535 ? $urandom : $urandom_range(lo, 65535));
      send_edge($urandom_range(800, 2200));
    end
    repeat ($urandom_range(1, 4)) read_channel();
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8)) begin
      send_item(2'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_reads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [spd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] sync, logic [15:0] gap, logic [15:0] servo,
                            logic [15:0] offs, logic [15:0] stale);
    drain();
    write_reg(spd_pkg::CFG_SYNC_PULSE_MIN, sync);
    write_reg(spd_pkg::CFG_CHANNEL_GAP_MAX, gap);
    write_reg(spd_pkg::CFG_SINGLE_SERVO_GAP_MIN, servo);
    write_reg(spd_pkg::CFG_CHANNEL_VALUE_OFFSET, offs);
    write_reg(spd_pkg::CFG_STALE_LIMIT_TICKS, stale);
    write_reg(spd_pkg::CFG_STALE_LIMIT_TICKS + 3'($urandom_range(1, 3)), 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int goal);
    while (n_items < goal) begin
      if ($urandom_range(0, 9) < 7) begin
        send_frame();
      end else begin
        send_noise();
      end
    end
  endtask

  task automatic run_directed();
    send_item(spd_pkg::FUNC_READ, 16'h0000, 8'd0);
    send_item(spd_pkg::FUNC_READ, 16'hFFFF, 8'd255);
    send_item(FUNC_UNUSED, 16'hFFFF, 8'hFF);
    send_item(spd_pkg::FUNC_TICK, 16'h0000, 8'h00);
    send_item(spd_pkg::FUNC_EDGE, 16'hFFFF, 8'h00);
    send_item(spd_pkg::FUNC_EDGE, 16'h1000, 8'hFF);
    send_item(spd_pkg::FUNC_EDGE, 16'h1064, 8'h00);
    send_item(spd_pkg::FUNC_EDGE, 16'h1640, 8'h00);
    send_item(spd_pkg::FUNC_READ, 16'h0000, 8'd2);
    send_item(spd_pkg::FUNC_READ, 16'h0000, 8'd1);
    send_item(spd_pkg::FUNC_READ, 16'h0000, 8'd0);
    send_item(spd_pkg::FUNC_READ, 16'h0000, 8'(spd_pkg::NUM_CHANNELS - 1));
    send_item(spd_pkg::FUNC_READ, 16'h0000, 8'(spd_pkg::NUM_CHANNELS));
    send_item(spd_pkg::FUNC_EDGE, 16'h6500, 8'h00);
    send_item(spd_pkg::FUNC_EDGE, 16'h6500, 8'h00);
    send_item(spd_pkg::FUNC_READ, 16'h0000, 8'd0);
    repeat (3) send_item(spd_pkg::FUNC_TICK, 16'hFFFF, 8'hFF);
    send_item(spd_pkg::FUNC_READ, 16'hFFFF, 8'd0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_phase(ITEMS_PER_PHASE);
    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(2 * ITEMS_PER_PHASE);
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(3 * ITEMS_PER_PHASE);
    set_config(16'($urandom_range(2000, 6000)), 16'($urandom_range(300, 1000)),
               16'($urandom_range(10000, 30000)), 16'($urandom),
               16'($urandom_range(1, 50)));
    run_phase(4 * ITEMS_PER_PHASE);
    set_config(spd_pkg::RST_SYNC_PULSE_MIN, spd_pkg::RST_CHANNEL_GAP_MAX,
               spd_pkg::RST_SINGLE_SERVO_GAP_MIN, 16'hFFFF, 16'd3);
    run_phase(5 * ITEMS_PER_PHASE);
    set_config(spd_pkg::RST_SYNC_PULSE_MIN, spd_pkg::RST_CHANNEL_GAP_MAX,
               spd_pkg::RST_SINGLE_SERVO_GAP_MIN, spd_pkg::RST_CHANNEL_VALUE_OFFSET,
               spd_pkg::RST_STALE_LIMIT_TICKS);
    idle_on = 1'b0;
    run_phase(6 * ITEMS_PER_PHASE);
    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_reads.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
